[hw/rtl/setwe_pkg.sv]
// Package for the sine-eased tween engine: widths, action codes, shared types
// and the sine-squared ease table, which is built when the design is elaborated.
// No dependencies.
`default_nettype none

package setwe_pkg;

  localparam int FRAME_BITS = 16;
  localparam int EASE_DEPTH = 256;
  localparam int EASE_BITS  = $clog2(EASE_DEPTH);
  localparam int EASE_Q     = 16;
  localparam int COORD_BITS = 16;
  localparam int COL_BITS   = 8;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int CDELTA_BITS = COL_BITS + 1;
  localparam int NUM_CHANS  = 8;
  localparam int CHAN_BITS  = $clog2(NUM_CHANS);
  localparam int PROD_BITS  = DELTA_BITS + EASE_Q + 1;

  localparam logic [63:0] PI_HALF_Q32 = 64'd6746518852;
  localparam logic [63:0] Q16_ONE     = 64'd65536;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_FORCE = 3'd2,
    ACT_PLACE = 3'd3,
    ACT_SYNC  = 3'd4
  } setwe_act_e;

  typedef struct packed {
    logic                 valid;
    logic [CHAN_BITS-1:0] chan;
  } setwe_tag_t;

  typedef logic [EASE_DEPTH-1:0][EASE_Q-1:0] ease_tab_t;

  function automatic logic [63:0] ease_half(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sn;
    longint      sum;
    int          k;
    x    = (PI_HALF_Q32 * j) / EASE_DEPTH;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = (((term * x) >> 32) * x) >> 32;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sn = 64'(sum);
    if (sn > 64'hFFFF_FFFF) begin
      sn = 64'hFFFF_FFFF;
    end
    return (((sn * sn) >> 32) + 64'd32768) >> 16;
  endfunction

  function automatic ease_tab_t ease_build();
    ease_tab_t   t;
    logic [63:0] s;
    logic [63:0] h;
    int          i;
    for (i = 0; i < EASE_DEPTH; i++) begin
      if (2 * i <= EASE_DEPTH) begin
        s = ease_half(64'(i));
      end else begin
        h = ease_half(64'(EASE_DEPTH - i));
        s = (h > Q16_ONE) ? 64'd0 : Q16_ONE - h;
      end
      if (s > 64'd65535) begin
        s = 64'd65535;
      end
      t[i] = s[EASE_Q-1:0];
    end
    return t;
  endfunction

  localparam ease_tab_t EASE_TAB = ease_build();

endpackage

`default_nettype wire

[hw/rtl/sine_eased_tween_engine_core.sv]
// Sine-eased tween engine for eight sprite channels (x, y, width, height, red, green,
// blue, alpha); it uses setwe_pkg, setwe_div and setwe_mac. Every request gives one
// result. A tick during a running move first runs the restoring divider that finds the
// ease table index, then reads the table. It then issues the channels into the shared
// two-stage multiplier, writes the last channel back and loads the output register.
// Every other request skips the divider and multiplier and goes straight on to load the
// output register. The input is taken again once the result is in the output register,
// even while that result still waits to be taken. A new result waits in its last cycle
// until the previous one has been taken.
`default_nettype none

module sine_eased_tween_engine_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // frames, value_x, value_y, value_w, value_h, value_r, value_g, value_b, value_a
  input  wire logic [111:0]  s_axis_tdata,
  // action
  input  wire logic [2:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // out_x, out_y, out_w, out_h, out_r, out_g, out_b, out_a
  output logic [95:0]        m_axis_tdata,
  // moving
  output logic               m_axis_tuser
);

  localparam int CB = setwe_pkg::COORD_BITS;
  localparam int KB = setwe_pkg::COL_BITS;
  localparam int FB = setwe_pkg::FRAME_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CB-1:0]                        cur_geo_q   [4];
  logic [KB-1:0]                        cur_col_q   [4];
  logic [CB-1:0]                        start_geo_q [4];
  logic [KB-1:0]                        start_col_q [4];
  logic signed [setwe_pkg::DELTA_BITS-1:0]  delta_geo_q [4];
  logic signed [setwe_pkg::CDELTA_BITS-1:0] delta_col_q [4];
  logic [CB-1:0]                        dest_geo_q  [4];
  logic [KB-1:0]                        dest_col_q  [4];
  logic [FB-1:0]                        elapsed_q;
  logic [FB-1:0]                        length_q;
  logic                                 in_motion_q;
  logic [setwe_pkg::EASE_Q-1:0]         ease_q;
  logic [setwe_pkg::CHAN_BITS:0]        iss_q;
  logic                                 m_valid_q;
  logic [95:0]                          m_data_q;
  logic                                 m_moving_q;

  logic [FB-1:0]                        in_frames;
  logic [CB-1:0]                        in_geo [4];
  logic [KB-1:0]                        in_col [4];
  setwe_pkg::setwe_act_e                act;
  logic                                 accept;
  logic                                 div_start;
  logic                                 div_done;
  logic [setwe_pkg::EASE_BITS-1:0]      div_quot;
  setwe_pkg::setwe_tag_t                iss_tag;
  setwe_pkg::setwe_tag_t                res_tag;
  logic [CB-1:0]                        mac_base;
  logic signed [setwe_pkg::DELTA_BITS-1:0] mac_delta;
  logic [CB-1:0]                        mac_res;
  logic [1:0]                           iss_lane;
  logic [1:0]                           res_lane;

  assign in_frames = s_axis_tdata[FB-1:0];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_geo[i] = s_axis_tdata[16 + 16 * i +: CB];
      in_col[i] = s_axis_tdata[80 + 8 * i +: KB];
    end
  end

  assign act           = setwe_pkg::setwe_act_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign div_start     = accept && (act == setwe_pkg::ACT_TICK) && in_motion_q
                         && (length_q > elapsed_q);

  assign iss_lane      = iss_q[1:0];
  assign iss_tag.valid = (state_q == ST_MUL) && !iss_q[setwe_pkg::CHAN_BITS];
  assign iss_tag.chan  = iss_q[setwe_pkg::CHAN_BITS-1:0];
  assign mac_base  = iss_tag.chan[2] ? {{(CB - KB){1'b0}}, start_col_q[iss_lane]}
                                     : start_geo_q[iss_lane];
  assign mac_delta = iss_tag.chan[2]
                     ? {{(setwe_pkg::DELTA_BITS - setwe_pkg::CDELTA_BITS)
                         {delta_col_q[iss_lane][setwe_pkg::CDELTA_BITS-1]}},
                        delta_col_q[iss_lane]}
                     : delta_geo_q[iss_lane];
  assign res_lane  = res_tag.chan[1:0];

  setwe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (elapsed_q),
    .den_i   (length_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  setwe_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (iss_tag),
    .base_i  (mac_base),
    .delta_i (mac_delta),
    .ease_i  (ease_q),
    .tag_o   (res_tag),
    .res_o   (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      length_q    <= '0;
      in_motion_q <= 1'b0;
      ease_q      <= '0;
      iss_q       <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_moving_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cur_geo_q[i]   <= '0;
        start_geo_q[i] <= '0;
        delta_geo_q[i] <= '0;
        dest_geo_q[i]  <= '0;
        cur_col_q[i]   <= '1;
        start_col_q[i] <= '1;
        delta_col_q[i] <= '0;
        dest_col_q[i]  <= '1;
      end
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DONE;
            case (act)
              setwe_pkg::ACT_TICK: begin
                if (in_motion_q) begin
                  if (length_q > elapsed_q) begin
                    state_q <= ST_DIV;
                  end else begin
                    in_motion_q <= 1'b0;
                    elapsed_q   <= '0;
                    cur_geo_q   <= dest_geo_q;
                    cur_col_q   <= dest_col_q;
                  end
                end
              end
              setwe_pkg::ACT_START: begin
                length_q    <= (in_frames > elapsed_q) ? (in_frames - elapsed_q) : '0;
                elapsed_q   <= '0;
                in_motion_q <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                  start_geo_q[i] <= cur_geo_q[i];
                  start_col_q[i] <= cur_col_q[i];
                  delta_geo_q[i] <= $signed({in_geo[i][CB-1], in_geo[i]})
                                    - $signed({cur_geo_q[i][CB-1], cur_geo_q[i]});
                  delta_col_q[i] <= $signed({1'b0, in_col[i]})
                                    - $signed({1'b0, cur_col_q[i]});
                  dest_geo_q[i]  <= in_geo[i];
                  dest_col_q[i]  <= in_col[i];
                end
              end
              setwe_pkg::ACT_FORCE: begin
                cur_geo_q   <= dest_geo_q;
                cur_col_q   <= dest_col_q;
                elapsed_q   <= '0;
                length_q    <= '0;
                in_motion_q <= 1'b0;
              end
              setwe_pkg::ACT_PLACE: begin
                cur_geo_q <= in_geo;
                cur_col_q <= in_col;
              end
              setwe_pkg::ACT_SYNC: begin
                dest_geo_q <= cur_geo_q;
                dest_col_q <= cur_col_q;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ease_q  <= setwe_pkg::EASE_TAB[div_quot];
            iss_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!iss_q[setwe_pkg::CHAN_BITS]) begin
            iss_q <= iss_q + 1'b1;
          end
          if (res_tag.valid) begin
            if (res_tag.chan[2]) begin
              cur_col_q[res_lane] <= mac_res[KB-1:0];
            end else begin
              cur_geo_q[res_lane] <= mac_res;
            end
            if (res_tag.chan == '1) begin
              elapsed_q <= elapsed_q + 1'b1;
              state_q   <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_data_q   <= {cur_col_q[3], cur_col_q[2], cur_col_q[1], cur_col_q[0],
                           cur_geo_q[3], cur_geo_q[2], cur_geo_q[1], cur_geo_q[0]};
            m_moving_q <= in_motion_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_moving_q;

  a_mac_only_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_tag.valid |-> state_q == ST_MUL)
    else $error("multiplier result outside the multiply phase");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_mul_inside_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> in_motion_q && (elapsed_q < length_q))
    else $error("easing step without a running move");

  a_stop_snaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_motion_q) |-> (cur_geo_q[0] == dest_geo_q[0]) && (cur_col_q[3] == dest_col_q[3]))
    else $error("move ended without reaching its destination");

endmodule

`default_nettype wire

[hw/rtl/setwe_div.sv]
// Restoring divider that gives the ease table index floor(elapsed * depth / length).
// One quotient bit per cycle. Depends on setwe_pkg.
`default_nettype none

module setwe_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [setwe_pkg::FRAME_BITS-1:0]     num_i,
  input  wire logic [setwe_pkg::FRAME_BITS-1:0]     den_i,
  output logic                                      done_o,
  output logic [setwe_pkg::EASE_BITS-1:0]           quot_o
);

  localparam int CntBits = $clog2(setwe_pkg::EASE_BITS + 1);

  logic [setwe_pkg::FRAME_BITS:0]   rem_q;
  logic [setwe_pkg::FRAME_BITS:0]   rem2;
  logic [setwe_pkg::FRAME_BITS-1:0] den_q;
  logic [setwe_pkg::EASE_BITS-1:0]  quot_q;
  logic [CntBits-1:0]               cnt_q;
  logic                             done_q;
  logic                             fits;

  assign rem2 = {rem_q[setwe_pkg::FRAME_BITS-1:0], 1'b0};
  assign fits = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntBits'(setwe_pkg::EASE_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntBits'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? (rem2 - {1'b0, den_q}) : rem2;
      quot_q <= {quot_q[setwe_pkg::EASE_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[hw/rtl/setwe_mac.sv]
// Shared two-stage multiply, round and add unit: base + floor((delta * s + half) / 2^16).
// Serves all eight channels in turn. Depends on setwe_pkg.
`default_nettype none

module setwe_mac (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire setwe_pkg::setwe_tag_t                 tag_i,
  input  wire logic [setwe_pkg::COORD_BITS-1:0]      base_i,
  input  wire logic signed [setwe_pkg::DELTA_BITS-1:0] delta_i,
  input  wire logic [setwe_pkg::EASE_Q-1:0]          ease_i,
  output setwe_pkg::setwe_tag_t                      tag_o,
  output logic [setwe_pkg::COORD_BITS-1:0]           res_o
);

  localparam int PB = setwe_pkg::PROD_BITS;

  logic signed [PB-1:0]               prod_q;
  logic signed [PB-1:0]               sum;
  logic [setwe_pkg::COORD_BITS-1:0]   base_q;
  logic [setwe_pkg::COORD_BITS-1:0]   res_q;
  setwe_pkg::setwe_tag_t              tag1_q;
  setwe_pkg::setwe_tag_t              tag2_q;

  assign sum = prod_q + PB'(1 << (setwe_pkg::EASE_Q - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PB'(delta_i) * PB'($signed({1'b0, ease_i}));
    base_q <= base_i;
    res_q  <= base_q + sum[setwe_pkg::EASE_Q +: setwe_pkg::COORD_BITS];
  end

  assign tag_o = tag2_q;
  assign res_o = res_q;

endmodule

`default_nettype wire
